>>> design/ribl_pkg.sv
// ribl_pkg: types, codes and sizing constants for the rank indexed byte list
// used by ribl_cell, rank_indexed_byte_list and ribl_checker; no dependencies
`default_nettype none
package ribl_pkg;

  localparam int CAPACITY = 32;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CMP_W    = (CNT_W > 5) ? CNT_W : 5;
  localparam int SORT_W   = IDX_W;

  // request codes carried in req_type
  localparam logic [2:0] REQ_READ    = 3'd0;
  localparam logic [2:0] REQ_INSERT  = 3'd1;
  localparam logic [2:0] REQ_REPLACE = 3'd2;
  localparam logic [2:0] REQ_REMOVE  = 3'd3;
  localparam logic [2:0] REQ_SORT    = 3'd4;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_RANK       = 2'd1,
    ST_FULL_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_INSERT,
    OP_REPLACE,
    OP_REMOVE,
    OP_SORT
  } list_op_e;

  typedef enum logic [1:0] {
    ACT_HOLD,
    ACT_LOAD,
    ACT_TAKE_LOWER,
    ACT_TAKE_UPPER
  } cell_act_e;

  typedef enum logic {
    CTL_IDLE,
    CTL_SORT
  } ctl_state_e;

  typedef struct packed {
    cell_act_e   act;
    logic [7:0]  load;
  } cell_ctrl_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic [4:0] rank;
    logic [7:0] value;
  } req_t;

  typedef struct packed {
    logic [7:0] read_value;
    logic [5:0] count;
    logic [1:0] status;
  } rsp_t;

endpackage
`default_nettype wire

>>> design/ribl_cell.sv
// ribl_cell: one byte of list storage, loads, holds or takes a neighbour's byte
// depends on ribl_pkg for cell_ctrl_t
`default_nettype none
module ribl_cell (
  input  wire logic                 clk_i,
  input  wire ribl_pkg::cell_ctrl_t ctrl_i,
  input  wire logic [7:0]           lower_i,
  input  wire logic [7:0]           upper_i,
  output logic      [7:0]           data_o
);

  logic [7:0] data_q;
  logic [7:0] data_d;

  always_comb begin
    unique case (ctrl_i.act)
      ribl_pkg::ACT_LOAD:       data_d = ctrl_i.load;
      ribl_pkg::ACT_TAKE_LOWER: data_d = lower_i;
      ribl_pkg::ACT_TAKE_UPPER: data_d = upper_i;
      default:                  data_d = data_q;
    endcase
  end

  // payload only, no reset
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule
`default_nettype wire

>>> design/rank_indexed_byte_list.sv
// rank_indexed_byte_list: top level, request decode, control and the row of cells
// depends on ribl_pkg and ribl_cell
//
// usage
// - request channel in_valid_i / in_stall_o / in_data_i carries one transaction per
//   request: req_type, rank and value
// - response channel out_valid_o / out_stall_i / out_data_o returns exactly one
//   transaction per request: read_value, count, status
// - read, insert, replace and remove are done in the cycle of acceptance: the whole
//   row of cells shifts in parallel; the response is registered, so it shows in the
//   cycle after acceptance; one such request can be taken each cycle unless stalled
// - sort runs an odd-even transposition sweep through the row, one compare and
//   swap phase a cycle; the request port stalls for the whole sweep and the
//   response appears in the cycle after the last phase
// - a new request is taken while the response register is empty or being taken in
//   the same cycle; while the receiver stalls a held response, requests stall too
// - reset clears the element count, the control state and the response valid;
//   cell contents are left as they are and only ranks below the count are visible
`default_nettype none
module rank_indexed_byte_list (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire ribl_pkg::req_t  in_data_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output ribl_pkg::rsp_t       out_data_o
);

  localparam int CAP = ribl_pkg::CAPACITY;

  ribl_pkg::ctl_state_e         state_q, state_d;
  logic [ribl_pkg::SORT_W-1:0]  phase_cnt_q, phase_cnt_d;
  logic [ribl_pkg::CNT_W-1:0]   count_q, count_d;
  logic                         out_valid_q, out_valid_d;
  ribl_pkg::rsp_t               out_q, out_d;
  ribl_pkg::list_op_e           op;

  logic [7:0]                   cell_data [CAP];
  logic [7:0]                   read_byte;
  logic [ribl_pkg::IDX_W-1:0]   rank_idx;
  logic [ribl_pkg::CMP_W-1:0]   rank_c;
  logic [ribl_pkg::CMP_W-1:0]   count_c;
  logic [ribl_pkg::CNT_W+5:0]   count_wide;
  logic                         accept;
  logic                         out_take;
  logic                         phase;

  assign out_take   = out_valid_q && !out_stall_i;
  assign in_stall_o = (state_q == ribl_pkg::CTL_SORT) || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;

  assign rank_idx   = ribl_pkg::IDX_W'(in_data_i.rank);
  assign rank_c     = ribl_pkg::CMP_W'(in_data_i.rank);
  assign count_c    = ribl_pkg::CMP_W'(count_q);
  assign read_byte  = cell_data[rank_idx];
  assign phase      = phase_cnt_q[0];
  // count field is the low six bits of the updated count
  assign count_wide = (ribl_pkg::CNT_W + 6)'(count_d);

  // control state machine: request decode and sort sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ribl_pkg::CTL_IDLE;
      phase_cnt_q <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_cnt_q <= phase_cnt_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_comb begin
    logic [7:0]          rd;
    ribl_pkg::status_e   st;
    logic                respond;
    state_d     = state_q;
    phase_cnt_d = phase_cnt_q;
    count_d     = count_q;
    out_valid_d = out_take ? 1'b0 : out_valid_q;
    out_d       = out_q;
    op          = ribl_pkg::OP_HOLD;
    rd          = 8'd0;
    st          = ribl_pkg::ST_OK;
    respond     = 1'b0;

    unique case (state_q)
      ribl_pkg::CTL_IDLE: begin
        if (accept) begin
          respond = 1'b1;
          unique case (in_data_i.req_type)
            ribl_pkg::REQ_READ: begin
              if (rank_c >= count_c) st = ribl_pkg::ST_RANK;
              else                   rd = read_byte;
            end
            ribl_pkg::REQ_INSERT: begin
              // full check before the rank check
              if (count_q == ribl_pkg::CNT_W'(CAP)) begin
                st = ribl_pkg::ST_FULL_EMPTY;
              end else if (rank_c > count_c) begin
                st = ribl_pkg::ST_RANK;
              end else begin
                op      = ribl_pkg::OP_INSERT;
                count_d = count_q + ribl_pkg::CNT_W'(1);
              end
            end
            ribl_pkg::REQ_REPLACE: begin
              if (rank_c >= count_c) st = ribl_pkg::ST_RANK;
              else                   op = ribl_pkg::OP_REPLACE;
            end
            ribl_pkg::REQ_REMOVE: begin
              // empty check before the rank check
              if (count_q == '0) begin
                st = ribl_pkg::ST_FULL_EMPTY;
              end else if (rank_c >= count_c) begin
                st = ribl_pkg::ST_RANK;
              end else begin
                op      = ribl_pkg::OP_REMOVE;
                count_d = count_q - ribl_pkg::CNT_W'(1);
              end
            end
            ribl_pkg::REQ_SORT: begin
              respond     = 1'b0;
              state_d     = ribl_pkg::CTL_SORT;
              phase_cnt_d = '0;
            end
            default: ;  // unknown request: ok, nothing changes
          endcase
        end
      end
      ribl_pkg::CTL_SORT: begin
        op          = ribl_pkg::OP_SORT;
        phase_cnt_d = phase_cnt_q + ribl_pkg::SORT_W'(1);
        if (phase_cnt_q == ribl_pkg::SORT_W'(CAP - 1)) begin
          state_d = ribl_pkg::CTL_IDLE;
          respond = 1'b1;
        end
      end
      default: ;
    endcase

    if (respond) begin
      out_valid_d      = 1'b1;
      out_d.read_value = rd;
      out_d.count      = count_wide[5:0];
      out_d.status     = st;
    end
  end

  // compare and swap pairs: pair p joins cells p and p+1, active on matching parity
  logic [CAP-1:0] swap_up;  // cell takes its upper neighbour
  logic [CAP-1:0] swap_dn;  // cell takes its lower neighbour

  for (genvar p = 0; p < CAP; p++) begin : g_pair
    if (p < CAP - 1) begin : g_has_up
      assign swap_up[p] = (p + 1 < int'(count_q)) && ((p % 2) == int'(phase))
                          && (cell_data[p] < cell_data[p+1]);
    end else begin : g_no_up
      assign swap_up[p] = 1'b0;
    end
    if (p > 0) begin : g_has_dn
      assign swap_dn[p] = swap_up[p-1];
    end else begin : g_no_dn
      assign swap_dn[p] = 1'b0;
    end
  end

  // row of cells
  for (genvar i = 0; i < CAP; i++) begin : g_cell
    ribl_pkg::cell_ctrl_t ctrl;
    logic [7:0]           lower;
    logic [7:0]           upper;

    if (i > 0) begin : g_lo
      assign lower = cell_data[i-1];
    end else begin : g_lo_edge
      assign lower = cell_data[i];
    end
    if (i < CAP - 1) begin : g_hi
      assign upper = cell_data[i+1];
    end else begin : g_hi_edge
      assign upper = cell_data[i];
    end

    always_comb begin
      ctrl.load = in_data_i.value;
      ctrl.act  = ribl_pkg::ACT_HOLD;
      unique case (op)
        ribl_pkg::OP_INSERT: begin
          if (i == int'(in_data_i.rank))     ctrl.act = ribl_pkg::ACT_LOAD;
          else if (i > int'(in_data_i.rank)) ctrl.act = ribl_pkg::ACT_TAKE_LOWER;
        end
        ribl_pkg::OP_REPLACE: begin
          if (i == int'(in_data_i.rank)) ctrl.act = ribl_pkg::ACT_LOAD;
        end
        ribl_pkg::OP_REMOVE: begin
          if (i >= int'(in_data_i.rank)) ctrl.act = ribl_pkg::ACT_TAKE_UPPER;
        end
        ribl_pkg::OP_SORT: begin
          if (swap_up[i])      ctrl.act = ribl_pkg::ACT_TAKE_UPPER;
          else if (swap_dn[i]) ctrl.act = ribl_pkg::ACT_TAKE_LOWER;
        end
        default: ;
      endcase
    end

    ribl_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .lower_i (lower),
      .upper_i (upper),
      .data_o  (cell_data[i])
    );
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

>>> design/ribl_checker.sv
// ribl_checker: port level assertions for rank_indexed_byte_list, with its bind
// depends on ribl_pkg
`default_nettype none
module ribl_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           in_valid_i,
  input wire logic           in_stall_o,
  input wire ribl_pkg::req_t in_data_i,
  input wire logic           out_valid_o,
  input wire logic           out_stall_i,
  input wire ribl_pkg::rsp_t out_data_o
);

  // a stalled response stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("response dropped while stalled");

  // read data is zero unless the request succeeded
  a_rd_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != ribl_pkg::ST_OK) |-> out_data_o.read_value == 8'd0)
    else $error("read value set on a failed request");

  // count never passes the capacity
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (ribl_pkg::CAPACITY > 63) || (int'(out_data_o.count) <= ribl_pkg::CAPACITY))
    else $error("count beyond capacity");

  // an accepted sort holds off the next request
  a_sort_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_data_i.req_type == ribl_pkg::REQ_SORT) |=> in_stall_o)
    else $error("request taken during sort");

endmodule

bind rank_indexed_byte_list ribl_checker u_ribl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
`default_nettype wire
